// ----- rtl/byte_ring_buffer_with_peek_assert.svh -----
// Assertion macros used by the checker of the byte ring buffer.
`ifndef BYTE_RING_BUFFER_WITH_PEEK_ASSERT_SVH
`define BYTE_RING_BUFFER_WITH_PEEK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brb check failed");

// Consequent must hold in the cycle after the antecedent.
`define BRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brb check failed");

`endif

// ----- rtl/brb_pkg.sv -----
package brb_pkg;

  // fixed field widths
  localparam int CNT_W       = 11;  // count, capacity, levels on the ports
  localparam int CAP_W       = 12;  // internal capacity / free level, holds 2048
  localparam int WB_W        = 64;  // write_bytes
  localparam int PTR_MAX_W   = 16;  // widest pointer over the depth range
  localparam int N_MAX_W     = 7;   // widest byte count per item (64)
  localparam int BYTE_SEL_W  = 3;   // byte lane in write_bytes

  // defaults for the top-level parameters
  localparam int STORE_DEPTH_DEF     = 1024;
  localparam int MAX_READ_BYTES_DEF  = 64;
  localparam int MAX_WRITE_BYTES_DEF = 8;

  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  // command codes on the kind field
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_PEEK   = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOM  = 2'd1,
    ST_NO_DATA  = 2'd2,
    ST_TOO_LONG = 2'd3
  } brb_status_t;

  // what the back end has to do for a queued command
  typedef enum logic [1:0] {
    OP_REPORT,
    OP_WRITE,
    OP_READ
  } brb_op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_RD_REQ,
    BK_RD_OUT,
    BK_RESULT
  } bk_state_t;

  typedef struct packed {
    brb_op_t                op;
    brb_status_t            status;
    logic [PTR_MAX_W-1:0]   ptr;
    logic [N_MAX_W-1:0]     n;
    logic [WB_W-1:0]        wbytes;
    logic [CNT_W-1:0]       done;
    logic [CNT_W-1:0]       free;
    logic                   empty;
    logic                   full;
  } brb_desc_t;

  // round up to a multiple of four, then saturate to 4 .. top
  function automatic logic [CAP_W-1:0] brb_clamp_cap(input logic [CNT_W-1:0] v,
                                                     input int top);
    logic [CAP_W-1:0] r;
    int               t;
    r      = CAP_W'(v) + CAP_W'(3);
    r[1:0] = 2'b00;
    t      = (top < 4) ? 4 : top;
    if (r < CAP_W'(4)) r = CAP_W'(4);
    if (int'(r) > t) r = CAP_W'(t);
    return r;
  endfunction

endpackage

// ----- rtl/brb_ifs.sv -----
interface brb_in_if import brb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [CNT_W-1:0] count;
  logic [WB_W-1:0]  write_bytes;

  modport source (output valid, kind, count, write_bytes, input ready);
  modport sink   (input valid, kind, count, write_bytes, output ready);
endinterface

interface brb_out_if import brb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [7:0]       data_byte;
  logic             last;
  logic [CNT_W-1:0] done_count;
  logic [CNT_W-1:0] free_level;
  logic             is_empty;
  logic             is_full;

  modport source (output valid, status, data_byte, last, done_count, free_level,
                  is_empty, is_full, input ready);
  modport sink   (input valid, status, data_byte, last, done_count, free_level,
                  is_empty, is_full, output ready);
endinterface

// ----- rtl/byte_ring_buffer_with_peek.sv -----
// Byte ring buffer: write chunk, read and pop, peek, remove; status decided when taken.
// Front end decides an item in the cycle it is taken and queues it (2 entries deep).
// Back end, one byte-wide store port: a write stores its bytes one by one, then reports;
// a read or peek does one store read then one result per byte; others only report.
// The back end takes the next queued item only when idle. Sync active-low reset:
// capacity 1024 (at most the store depth), empty (contents kept).
module byte_ring_buffer_with_peek import brb_pkg::*; #(
  parameter int STORE_DEPTH     = STORE_DEPTH_DEF,
  parameter int MAX_READ_BYTES  = MAX_READ_BYTES_DEF,
  parameter int MAX_WRITE_BYTES = MAX_WRITE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // capacity register; writing it empties the store
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  brb_in_if.sink           in_ch,
  brb_out_if.source        out_ch
);

  brb_desc_t        push_desc, head_desc;
  logic             q_push, q_full, q_valid, q_pop;
  logic [CAP_W-1:0] cap;

  // Front: owns capacity, pointers and free level. All status and level
  // results are known here; the back end uses only the capacity, to wrap its pointer.
  brb_front #(
    .STORE_DEPTH     (STORE_DEPTH),
    .MAX_READ_BYTES  (MAX_READ_BYTES),
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc),
    .cap       (cap)
  );

  // Command queue; items are carried out in order, so a read queued behind
  // a write always sees the written bytes.
  brb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head_desc),
    .pop       (q_pop)
  );

  // Back: byte store and result sequencing, one byte per step.
  brb_back #(
    .STORE_DEPTH     (STORE_DEPTH),
    .MAX_READ_BYTES  (MAX_READ_BYTES),
    .MAX_WRITE_BYTES (MAX_WRITE_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cap     (cap),
    .q_valid (q_valid),
    .q_desc  (head_desc),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- rtl/brb_front.sv -----
module brb_front import brb_pkg::*; #(
  parameter int STORE_DEPTH     = STORE_DEPTH_DEF,
  parameter int MAX_READ_BYTES  = MAX_READ_BYTES_DEF,
  parameter int MAX_WRITE_BYTES = MAX_WRITE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  brb_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             q_push,
  output brb_desc_t        q_desc,
  output logic [CAP_W-1:0] cap
);

  localparam int PTR_W   = $clog2(STORE_DEPTH);
  localparam int CAP_TOP = STORE_DEPTH & ~3;
  localparam int SUM_W   = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;

  logic [CAP_W-1:0] cap_r, free_r, free_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CAP_W-1:0] stored, count_x, done_v;
  logic             accept;

  // p + n modulo capacity; p < cap and n <= cap, so one subtract suffices
  function automatic logic [PTR_W-1:0] add_wrap(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] n,
                                                input logic [CAP_W-1:0] c);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(p) + SUM_W'(n);
    if (sum >= SUM_W'(c)) sum = sum - SUM_W'(c);
    return PTR_W'(sum);
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_push      = accept;
  assign cap         = cap_r;
  assign stored      = cap_r - free_r;
  assign count_x     = CAP_W'(in_ch.count);

  always_comb begin
    q_desc        = '0;
    q_desc.op     = OP_REPORT;
    q_desc.status = ST_OK;
    q_desc.wbytes = in_ch.write_bytes;
    done_v        = '0;
    free_nxt      = free_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    unique case (in_ch.kind) inside
      KIND_WRITE: begin
        if (in_ch.count > CNT_W'(MAX_WRITE_BYTES)) begin
          q_desc.status = ST_TOO_LONG;
        end else if (count_x > free_r) begin
          q_desc.status = ST_NO_ROOM;
        end else begin
          if (in_ch.count != '0) q_desc.op = OP_WRITE;
          q_desc.ptr = PTR_MAX_W'(wp_r);
          q_desc.n   = N_MAX_W'(in_ch.count);
          wp_nxt     = add_wrap(wp_r, count_x, cap_r);
          free_nxt   = free_r - count_x;
          done_v     = count_x;
        end
      end
      KIND_READ, KIND_PEEK: begin
        if (in_ch.count > CNT_W'(MAX_READ_BYTES)) begin
          q_desc.status = ST_TOO_LONG;
        end else if (count_x > stored) begin
          q_desc.status = ST_NO_DATA;
        end else if (in_ch.count != '0) begin
          q_desc.op  = OP_READ;
          q_desc.ptr = PTR_MAX_W'(rp_r);
          q_desc.n   = N_MAX_W'(in_ch.count);
          done_v     = count_x;
          if (in_ch.kind == KIND_READ) begin
            rp_nxt   = add_wrap(rp_r, count_x, cap_r);
            free_nxt = free_r + count_x;
          end
        end
      end
      KIND_REMOVE: begin
        if (count_x < stored) begin
          rp_nxt   = add_wrap(rp_r, count_x, cap_r);
          free_nxt = free_r + count_x;
          done_v   = count_x;
        end else begin
          rp_nxt   = wp_r;
          free_nxt = cap_r;
          done_v   = stored;
        end
      end
    endcase
    q_desc.done  = CNT_W'(done_v);
    q_desc.free  = CNT_W'(free_nxt);
    q_desc.empty = (free_nxt == cap_r);
    q_desc.full  = (free_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= brb_clamp_cap(CAP_RESET, CAP_TOP);
      free_r <= brb_clamp_cap(CAP_RESET, CAP_TOP);
      rp_r   <= '0;
      wp_r   <= '0;
    end else if (cfg_we) begin
      cap_r  <= brb_clamp_cap(cfg_wdata, CAP_TOP);
      free_r <= brb_clamp_cap(cfg_wdata, CAP_TOP);
      rp_r   <= '0;
      wp_r   <= '0;
    end else if (accept) begin
      free_r <= free_nxt;
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
    end
  end

endmodule

// ----- rtl/brb_queue.sv -----
module brb_queue import brb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  brb_desc_t push_desc,
  output logic      full,
  output logic      valid,
  output brb_desc_t head,
  input  logic      pop
);

  brb_desc_t  ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/brb_back.sv -----
module brb_back import brb_pkg::*; #(
  parameter int STORE_DEPTH     = STORE_DEPTH_DEF,
  parameter int MAX_READ_BYTES  = MAX_READ_BYTES_DEF,
  parameter int MAX_WRITE_BYTES = MAX_WRITE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] cap,
  input  logic             q_valid,
  input  brb_desc_t        q_desc,
  output logic             q_pop,
  brb_out_if.source        out_ch
);

  localparam int PTR_W   = $clog2(STORE_DEPTH);
  localparam int MAX_N   = (MAX_READ_BYTES > MAX_WRITE_BYTES) ? MAX_READ_BYTES
                                                              : MAX_WRITE_BYTES;
  localparam int IDX_W   = $clog2(MAX_N + 1);
  localparam int WRAP_W  = ((PTR_W + 1) > CAP_W) ? (PTR_W + 1) : CAP_W;

  bk_state_t        state_r, state_nxt;
  brb_desc_t        cmd_r, cmd_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt, ptr_inc;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       store_mem_r [STORE_DEPTH];
  logic [7:0]       rdata_r, wbyte;
  logic             mem_we, mem_re, is_last;
  logic [WRAP_W-1:0] ptr_plus;

  // output register
  logic             out_valid_r, out_valid_nxt, out_free, out_load;
  logic [1:0]       o_status_r;
  logic [7:0]       o_data_r, o_data_nxt;
  logic             o_last_r, o_last_nxt;
  logic [CNT_W-1:0] o_done_r, o_free_r;
  logic             o_empty_r, o_full_r;

  assign ptr_plus = WRAP_W'(ptr_r) + WRAP_W'(1);
  assign ptr_inc  = (ptr_plus == WRAP_W'(cap)) ? '0 : PTR_W'(ptr_plus);
  assign is_last  = (N_MAX_W'(idx_r) + N_MAX_W'(1)) == cmd_r.n;
  assign wbyte    = cmd_r.wbytes[8*BYTE_SEL_W'(idx_r) +: 8];
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    o_data_nxt = '0;
    o_last_nxt = 1'b1;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_desc;
          ptr_nxt = PTR_W'(q_desc.ptr);
          idx_nxt = '0;
          unique case (q_desc.op)
            OP_WRITE: state_nxt = BK_WRITE;
            OP_READ:  state_nxt = BK_RD_REQ;
            default:  state_nxt = BK_RESULT;
          endcase
        end
      end
      BK_WRITE: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_inc;
        idx_nxt = idx_r + IDX_W'(1);
        if (is_last) state_nxt = BK_RESULT;
      end
      BK_RD_REQ: begin
        mem_re    = 1'b1;
        state_nxt = BK_RD_OUT;
      end
      BK_RD_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_data_nxt = rdata_r;
          o_last_nxt = is_last;
          ptr_nxt    = ptr_inc;
          idx_nxt    = idx_r + IDX_W'(1);
          state_nxt  = is_last ? BK_IDLE : BK_RD_REQ;
        end
      end
      BK_RESULT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (out_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem_r[ptr_r] <= wbyte;
    if (mem_re) rdata_r <= store_mem_r[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    ptr_r <= ptr_nxt;
    idx_r <= idx_nxt;
    if (out_load) begin
      o_status_r <= cmd_r.status;
      o_data_r   <= o_data_nxt;
      o_last_r   <= o_last_nxt;
      o_done_r   <= cmd_r.done;
      o_free_r   <= cmd_r.free;
      o_empty_r  <= cmd_r.empty;
      o_full_r   <= cmd_r.full;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = o_status_r;
  assign out_ch.data_byte  = o_data_r;
  assign out_ch.last       = o_last_r;
  assign out_ch.done_count = o_done_r;
  assign out_ch.free_level = o_free_r;
  assign out_ch.is_empty   = o_empty_r;
  assign out_ch.is_full    = o_full_r;

endmodule

// ----- rtl/brb_checker.sv -----
`include "byte_ring_buffer_with_peek_assert.svh"

module brb_checker import brb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_status,
  input logic [7:0]       out_data_byte,
  input logic             out_last,
  input logic [CNT_W-1:0] out_done_count,
  input logic [CNT_W-1:0] out_free_level,
  input logic             out_is_empty,
  input logic             out_is_full
);

  // a stalled result stays offered
  `BRB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // an error answer is a single, empty result
  `BRB_ASSERT_NOW(a_err_single, clk, rst_n, out_valid && (out_status != ST_OK),
                  out_last && (out_data_byte == 8'd0) && (out_done_count == '0))

  // capacity is at least four, so empty and full never coincide
  `BRB_ASSERT_NOW(a_not_both, clk, rst_n, out_valid, !(out_is_empty && out_is_full))

  `BRB_ASSERT_NOW(a_full_level, clk, rst_n, out_valid && out_is_full,
                  out_free_level == '0)

endmodule

bind byte_ring_buffer_with_peek brb_checker u_brb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_data_byte  (out_ch.data_byte),
  .out_last       (out_ch.last),
  .out_done_count (out_ch.done_count),
  .out_free_level (out_ch.free_level),
  .out_is_empty   (out_ch.is_empty),
  .out_is_full    (out_ch.is_full)
);
